### hw/rtl/csfd_pkg.sv
// Package for the CAN signal field decoder: status codes and the words
// passed between the pipeline sections. No dependencies.
package csfd_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_FIELD = 2'd2,
    ST_RANGE     = 2'd3
  } csfd_status_t;

  // Word from the field extractor to the multiply-add section.
  typedef struct packed {
    csfd_status_t status;
    logic [63:0]  raw;
    logic [31:0]  scale;
    logic [63:0]  offset;
    logic [63:0]  min_limit;
    logic [63:0]  max_limit;
  } csfd_raw_t;

  // Word from the multiply-add section to the limit check.
  typedef struct packed {
    csfd_status_t status;
    logic [63:0]  raw;
    logic [63:0]  phys;
    logic [63:0]  min_limit;
    logic [63:0]  max_limit;
  } csfd_phys_t;

endpackage

### hw/rtl/can_signal_field_decoder.sv
// Top level of the CAN signal field decoder: extractor, multiply-add and
// limit check in a six-stage pipeline. Uses csfd_pkg and the csfd_* modules.
//
// Each input word on the in_ channel carries one payload and one signal
// definition; each output word on the out_ channel carries its status, the
// raw field and the scaled physical value. Both channels use valid/ready.
// One word enters per cycle while the receiver takes results: every stage
// holds a valid bit and loads whenever the stage after it is empty or moving,
// so the pipeline sets the rate, not any shared unit.
// The stage count follows from the 64 x 32 multiply, done as two partial
// products, then product assembly and the 97-bit offset add.
// When the receiver stalls, the result stays in the output register and the
// earlier stages keep filling their empty slots; in_ready falls only when all
// six stages hold words. Reset clears every valid bit, so the block comes out
// of reset empty and ready. A short frame or a bad field gives a zero raw and
// physical value with the matching status.
module can_signal_field_decoder #(
  parameter int FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_frame_data,
  input  logic [3:0]  in_frame_length,
  input  logic [3:0]  in_message_length,
  input  logic [5:0]  in_start_bit,
  input  logic [6:0]  in_bit_length,
  input  logic        in_little_endian,
  input  logic        in_is_signed,
  input  logic signed [31:0] in_scale_factor,
  input  logic signed [63:0] in_offset_value,
  input  logic signed [63:0] in_min_limit,
  input  logic signed [63:0] in_max_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_raw_value,
  output logic signed [63:0] out_physical_value
);
  import csfd_pkg::*;

  logic       ext_valid;
  logic       ext_ready;
  csfd_raw_t  ext_word;
  logic       mac_valid;
  logic       mac_ready;
  csfd_phys_t mac_word;

  csfd_extract #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_extract (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .frame_data    (in_frame_data),
    .frame_length  (in_frame_length),
    .message_length(in_message_length),
    .start_bit     (in_start_bit),
    .bit_length    (in_bit_length),
    .little_endian (in_little_endian),
    .is_signed     (in_is_signed),
    .scale_factor  (in_scale_factor),
    .offset_value  (in_offset_value),
    .min_limit     (in_min_limit),
    .max_limit     (in_max_limit),
    .out_valid     (ext_valid),
    .out_ready     (ext_ready),
    .out_word      (ext_word)
  );

  csfd_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ext_valid),
    .in_ready (ext_ready),
    .in_word  (ext_word),
    .out_valid(mac_valid),
    .out_ready(mac_ready),
    .out_word (mac_word)
  );

  csfd_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (mac_valid),
    .in_ready          (mac_ready),
    .in_word           (mac_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_raw_value     (out_raw_value),
    .out_physical_value(out_physical_value)
  );

  // A rejected frame or field never carries a value.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SHORT || out_status == ST_BAD_FIELD) |->
      out_raw_value == 64'd0 && out_physical_value == 64'd0)
    else $error("rejected word carries a nonzero value");

  // Back-pressure reaches the input only when the output is held.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output moves");

  // The pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

### hw/rtl/csfd_extract.sv
// Field extractor: length and field checks, bit gathering in either byte
// order, masking and sign extension over two register stages. Uses csfd_pkg.
module csfd_extract #(
  parameter int FRAME_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        frame_data,
  input  logic [3:0]         frame_length,
  input  logic [3:0]         message_length,
  input  logic [5:0]         start_bit,
  input  logic [6:0]         bit_length,
  input  logic               little_endian,
  input  logic               is_signed,
  input  logic [31:0]        scale_factor,
  input  logic [63:0]        offset_value,
  input  logic [63:0]        min_limit,
  input  logic [63:0]        max_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output csfd_pkg::csfd_raw_t out_word
);
  import csfd_pkg::*;

  localparam logic [3:0] MaxBytes = (FRAME_BYTES > 8) ? 4'd8 : 4'(FRAME_BYTES);

  // Stage 1 registers.
  logic         s1_v_r;
  csfd_status_t s1_status_r;
  logic [63:0]  s1_field_r;
  logic [6:0]   s1_len_r;
  logic         s1_signed_r;
  logic [31:0]  s1_scale_r;
  logic [63:0]  s1_offset_r;
  logic [63:0]  s1_min_r;
  logic [63:0]  s1_max_r;
  // Stage 2 registers.
  logic         s2_v_r;
  csfd_raw_t    s2_word_r;

  logic         s1_adv;
  logic         s2_adv;
  logic [3:0]   bytes_eff;
  logic [6:0]   usable_bits;
  logic [7:0]   end_bit;
  logic [7:0]   low_bit;
  logic         len_bad;
  logic         intel_bad;
  logic         moto_bad;
  logic [63:0]  moto_data;
  logic [5:0]   shamt;
  logic [63:0]  field_nxt;
  csfd_status_t status_nxt;
  logic [63:0]  mask;
  logic         sign_bit;
  csfd_raw_t    word_nxt;

  assign s2_adv   = !s2_v_r || out_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  always_comb begin
    bytes_eff   = (frame_length > MaxBytes) ? MaxBytes : frame_length;
    usable_bits = {bytes_eff, 3'b000};
    end_bit     = {2'b00, start_bit} + {1'b0, bit_length};
    low_bit     = {2'b00, start_bit} + 8'd1 - {1'b0, bit_length};
    len_bad     = (bit_length == 7'd0) || (bit_length > 7'd64);
    intel_bad   = end_bit > {1'b0, usable_bits};
    moto_bad    = (({2'b00, start_bit} + 8'd1) < {1'b0, bit_length}) ||
                  ({1'b0, start_bit} >= usable_bits);
    // Motorola numbering reverses the bit order inside each byte; after that
    // the field is a plain slice ending at the start bit.
    for (int i = 0; i < 64; i++) begin
      moto_data[i] = frame_data[(i & ~7) + (7 - (i & 7))];
    end
    shamt     = little_endian ? start_bit : low_bit[5:0];
    field_nxt = (little_endian ? frame_data : moto_data) >> shamt;
    if (frame_length < message_length) begin
      status_nxt = ST_SHORT;
    end else if (len_bad || (little_endian ? intel_bad : moto_bad)) begin
      status_nxt = ST_BAD_FIELD;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_comb begin
    mask     = ~({64{1'b1}} << s1_len_r);
    sign_bit = s1_signed_r && s1_field_r[6'(s1_len_r - 7'd1)];
    word_nxt.status    = s1_status_r;
    word_nxt.raw       = (s1_status_r == ST_OK) ?
                         ((s1_field_r & mask) | (sign_bit ? ~mask : 64'd0)) : 64'd0;
    word_nxt.scale     = s1_scale_r;
    word_nxt.offset    = s1_offset_r;
    word_nxt.min_limit = s1_min_r;
    word_nxt.max_limit = s1_max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_adv) begin
      s1_status_r <= status_nxt;
      s1_field_r  <= field_nxt;
      s1_len_r    <= bit_length;
      s1_signed_r <= is_signed;
      s1_scale_r  <= scale_factor;
      s1_offset_r <= offset_value;
      s1_min_r    <= min_limit;
      s1_max_r    <= max_limit;
    end
    if (s1_v_r && s2_adv) begin
      s2_word_r <= word_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_word  = s2_word_r;

endmodule

### hw/rtl/csfd_mac.sv
// Multiply-add section: raw times scale as two 32-bit partial products,
// product assembly, then offset add with saturation. Uses csfd_pkg.
module csfd_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csfd_pkg::csfd_raw_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csfd_pkg::csfd_phys_t out_word
);
  import csfd_pkg::*;

  logic               s3_v_r;
  logic               s4_v_r;
  logic               s5_v_r;
  logic               s3_adv;
  logic               s4_adv;
  logic               s5_adv;

  csfd_raw_t          s3_word_r;
  logic signed [64:0] s3_plo_r;
  logic signed [63:0] s3_phi_r;
  csfd_raw_t          s4_word_r;
  logic [95:0]        s4_prod_r;
  csfd_phys_t         s5_word_r;

  logic signed [32:0] raw_lo;
  logic signed [31:0] raw_hi;
  logic signed [31:0] scale_s;
  logic signed [64:0] plo_nxt;
  logic signed [63:0] phi_nxt;
  logic [95:0]        prod_nxt;
  logic [96:0]        sum;
  logic [63:0]        sat;
  csfd_phys_t         word_nxt;

  assign s5_adv   = !s5_v_r || out_ready;
  assign s4_adv   = !s4_v_r || s5_adv;
  assign s3_adv   = !s3_v_r || s4_adv;
  assign in_ready = s3_adv;

  // The raw word splits into a signed upper half and an unsigned lower half.
  always_comb begin
    raw_lo  = $signed({1'b0, in_word.raw[31:0]});
    raw_hi  = $signed(in_word.raw[63:32]);
    scale_s = $signed(in_word.scale);
    plo_nxt = raw_lo * scale_s;
    phi_nxt = raw_hi * scale_s;
  end

  assign prod_nxt = {s3_phi_r, 32'd0} + {{31{s3_plo_r[64]}}, s3_plo_r};

  always_comb begin
    sum = {s4_prod_r[95], s4_prod_r} + {{33{s4_word_r.offset[63]}}, s4_word_r.offset};
    if (sum[96:63] == {34{sum[63]}}) begin
      sat = sum[63:0];
    end else if (sum[96]) begin
      sat = {1'b1, 63'd0};
    end else begin
      sat = {1'b0, {63{1'b1}}};
    end
    word_nxt.status    = s4_word_r.status;
    word_nxt.raw       = s4_word_r.raw;
    word_nxt.phys      = (s4_word_r.status == ST_OK) ? sat : 64'd0;
    word_nxt.min_limit = s4_word_r.min_limit;
    word_nxt.max_limit = s4_word_r.max_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (s3_adv) begin
        s3_v_r <= in_valid;
      end
      if (s4_adv) begin
        s4_v_r <= s3_v_r;
      end
      if (s5_adv) begin
        s5_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s3_adv) begin
      s3_word_r <= in_word;
      s3_plo_r  <= plo_nxt;
      s3_phi_r  <= phi_nxt;
    end
    if (s3_v_r && s4_adv) begin
      s4_word_r <= s3_word_r;
      s4_prod_r <= prod_nxt;
    end
    if (s4_v_r && s5_adv) begin
      s5_word_r <= word_nxt;
    end
  end

  assign out_valid = s5_v_r;
  assign out_word  = s5_word_r;

endmodule

### hw/rtl/csfd_check.sv
// Limit check and output register: flags a physical value outside the
// limits and holds the result word for the receiver. Uses csfd_pkg.
module csfd_check (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csfd_pkg::csfd_phys_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [63:0]          out_raw_value,
  output logic [63:0]          out_physical_value
);
  import csfd_pkg::*;

  logic         s6_v_r;
  logic         s6_adv;
  csfd_status_t status_nxt;
  csfd_status_t status_r;
  logic [63:0]  raw_r;
  logic [63:0]  phys_r;
  logic         below;
  logic         above;

  assign s6_adv   = !s6_v_r || out_ready;
  assign in_ready = s6_adv;

  always_comb begin
    below = $signed(in_word.phys) < $signed(in_word.min_limit);
    above = $signed(in_word.max_limit) < $signed(in_word.phys);
    if ((in_word.status == ST_OK) && (below || above)) begin
      status_nxt = ST_RANGE;
    end else begin
      status_nxt = in_word.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (s6_adv) begin
      s6_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s6_adv) begin
      status_r <= status_nxt;
      raw_r    <= in_word.raw;
      phys_r   <= in_word.phys;
    end
  end

  assign out_valid          = s6_v_r;
  assign out_status         = status_r;
  assign out_raw_value      = raw_r;
  assign out_physical_value = phys_r;

endmodule
